### hw/rtl/mpmc_pkg.sv
// Shared types and codes for the multi-pattern match counter.
// Depends on nothing; the matcher unit and the testbench files refer to it by scoped names.
package mpmc_pkg;

    // Input word: one command to the matcher
    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] symbol;
        logic [9:0] pattern_id;
    } t_in_word;

    // Output word: one response per command
    typedef struct packed {
        logic [15:0] count;
        logic [1:0]  status;
    } t_out_word;

    // Command kinds
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_PCHAR = 3'd1;
    localparam logic [2:0] KIND_PEND  = 3'd2;
    localparam logic [2:0] KIND_BUILD = 3'd3;
    localparam logic [2:0] KIND_START = 3'd4;
    localparam logic [2:0] KIND_SCAN  = 3'd5;
    localparam logic [2:0] KIND_READ  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NO_ID = 2'd2;

endpackage

### hw/rtl/mpmc_sat_inc.sv
// Saturating increment used on the occurrence counters.
// No dependencies.
module mpmc_sat_inc #(
    parameter int W = 16
) (
    input  logic [W-1:0] i_val,
    output logic [W-1:0] o_next,
    output logic         o_sat
);

    // at all ones the counter holds
    assign o_sat  = (i_val == {W{1'b1}});
    assign o_next = i_val + W'(1);

endmodule

### hw/rtl/multi_pattern_match_counter_unit.sv
// Aho-Corasick matcher: clear, trie insert, breadth-first link build, counter reset, scan, count read.
// A pattern char that adds a node also clears that node's row; build visits each queued node;
// scan walks the failure chain node by node, with an extra counter step on a hit; every
// response then goes into the output register.
// One word in work at a time; the single read port of each memory sets the step count.
// Reset (sync, active low) runs a clearing pass over the root row and the match counters.
module multi_pattern_match_counter_unit #(
    parameter int NODE_COUNT    = 4096,
    parameter int ALPHABET      = 128,
    parameter int PATTERN_COUNT = 1024,
    parameter int COUNT_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpmc_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpmc_pkg::t_out_word o_out_data
);

    localparam int NB       = $clog2(NODE_COUNT);
    localparam int SB       = $clog2(ALPHABET);
    localparam int GA       = NB + SB;
    localparam int GT_DEPTH = NODE_COUNT * (2 ** SB);
    localparam int MC_DEPTH = (PATTERN_COUNT < 1024) ? PATTERN_COUNT : 1024;
    localparam int MCW      = (MC_DEPTH > 1) ? $clog2(MC_DEPTH) : 1;
    localparam logic [8:0]    ALPHA_LIM = 9'(ALPHABET);
    localparam logic [16:0]   PC_LIM    = 17'(PATTERN_COUNT);
    localparam logic [NB:0]   NODE_LIM  = (NB+1)'(NODE_COUNT);
    localparam logic [SB:0]   SYM_LAST  = (SB+1)'(ALPHABET - 1);
    localparam logic [MCW:0]  MC_LAST   = (MCW+1)'(MC_DEPTH - 1);

    typedef enum logic [20:0] {
        S_INIT_ROW = 21'd1 << 0,
        S_INIT_MC  = 21'd1 << 1,
        S_IDLE     = 21'd1 << 2,
        S_CLR_ROW  = 21'd1 << 3,
        S_PC_CHK   = 21'd1 << 4,
        S_PC_ROW   = 21'd1 << 5,
        S_PC_LINK  = 21'd1 << 6,
        S_BA_RD    = 21'd1 << 7,
        S_BA_CHK   = 21'd1 << 8,
        S_BQ       = 21'd1 << 9,
        S_BU       = 21'd1 << 10,
        S_BF       = 21'd1 << 11,
        S_BC_RV    = 21'd1 << 12,
        S_BC_RW    = 21'd1 << 13,
        S_BC_ACT   = 21'd1 << 14,
        S_MC_CLR   = 21'd1 << 15,
        S_SC_V     = 21'd1 << 16,
        S_SC_NP    = 21'd1 << 17,
        S_SC_MC    = 21'd1 << 18,
        S_RD_MC    = 21'd1 << 19,
        S_FIN      = 21'd1 << 20
    } t_state;

    function automatic logic sym_ok(input logic [6:0] s);
        return {2'b00, s} < ALPHA_LIM;
    endfunction

    function automatic logic [SB-1:0] sidx(input logic [6:0] s);
        logic [7:0] e;
        e = {1'b0, s};
        return e[SB-1:0];
    endfunction

    function automatic logic id_ok(input logic [9:0] id);
        return {7'b0, id} < PC_LIM;
    endfunction

    // control registers
    t_state       r_state, n_state;
    logic [SB:0]  r_i, n_i;
    logic [MCW:0] r_mi, n_mi;
    logic [NB:0]  r_nodes, n_nodes;
    logic [NB-1:0] r_cur, n_cur;
    logic [NB-1:0] r_scan, n_scan;
    logic [NB:0]  r_head, n_head;
    logic [NB:0]  r_tail, n_tail;
    logic         r_built, n_built;
    logic         r_ov, n_ov;
    // payload registers
    logic [NB-1:0] r_u, n_u;
    logic [NB-1:0] r_f, n_f;
    logic [NB-1:0] r_v, n_v;
    logic [6:0]    r_sym, n_sym;
    logic [9:0]    r_id, n_id;
    mpmc_pkg::t_out_word r_res, n_res;
    mpmc_pkg::t_out_word r_odata, n_odata;

    // memory ports
    logic            gt_we;
    logic [GA-1:0]   gt_wa, gt_ra;
    logic [NB-1:0]   gt_wd, r_gt_q;
    logic            fl_we;
    logic [NB-1:0]   fl_wa, fl_ra, fl_wd, r_fl_q;
    logic            np_we;
    logic [NB-1:0]   np_wa, np_ra;
    logic [9:0]      np_wd, r_np_q;
    logic            mc_we;
    logic [MCW-1:0]  mc_wa, mc_ra;
    logic [COUNT_BITS-1:0] mc_wd, r_mc_q, mc_inc;
    logic            mc_sat;
    logic            q_we;
    logic [NB-1:0]   q_wa, q_ra, q_wd, r_q_q;
    logic [31:0]     cnt_ext;

    logic [NB-1:0] gt_mem [GT_DEPTH];
    logic [NB-1:0] fl_mem [NODE_COUNT];
    logic [9:0]    np_mem [NODE_COUNT];
    logic [COUNT_BITS-1:0] mc_mem [MC_DEPTH];
    logic [NB-1:0] q_mem  [NODE_COUNT];

    mpmc_sat_inc #(.W(COUNT_BITS)) u_inc (
        .i_val  (r_mc_q),
        .o_next (mc_inc),
        .o_sat  (mc_sat)
    );

    assign cnt_ext     = 32'(r_mc_q);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_odata;

    // sequencer
    always_comb begin
        n_state = r_state;  n_i = r_i;  n_mi = r_mi;  n_nodes = r_nodes;
        n_cur = r_cur;  n_scan = r_scan;  n_head = r_head;  n_tail = r_tail;
        n_built = r_built;  n_u = r_u;  n_f = r_f;  n_v = r_v;
        n_sym = r_sym;  n_id = r_id;  n_res = r_res;  n_odata = r_odata;
        n_ov = r_ov && i_out_stall;
        gt_we = 1'b0;  gt_wa = '0;  gt_wd = '0;  gt_ra = '0;
        fl_we = 1'b0;  fl_wa = '0;  fl_wd = '0;  fl_ra = '0;
        np_we = 1'b0;  np_wa = '0;  np_wd = '0;  np_ra = '0;
        mc_we = 1'b0;  mc_wa = '0;  mc_wd = '0;  mc_ra = '0;
        q_we  = 1'b0;  q_wa  = '0;  q_wd  = '0;  q_ra  = '0;

        case (r_state)
            S_INIT_ROW: begin
                gt_we = 1'b1;
                gt_wa = {NB'(0), r_i[SB-1:0]};
                n_i = r_i + 1'b1;
                if (r_i == SYM_LAST) begin
                    n_mi = '0;
                    n_state = S_INIT_MC;
                end
            end
            S_INIT_MC: begin
                mc_we = 1'b1;
                mc_wa = r_mi[MCW-1:0];
                n_mi = r_mi + 1'b1;
                if (r_mi == MC_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sym = i_in_data.symbol;
                    n_id  = i_in_data.pattern_id;
                    n_res.count  = '0;
                    n_res.status = mpmc_pkg::ST_OK;
                    n_state = S_FIN;
                    case (i_in_data.kind)
                        mpmc_pkg::KIND_CLEAR: begin
                            n_nodes = (NB+1)'(1);
                            n_cur = '0;
                            n_scan = '0;
                            n_built = 1'b0;
                            n_i = '0;
                            n_state = S_CLR_ROW;
                        end
                        mpmc_pkg::KIND_PCHAR: begin
                            if (!r_built && sym_ok(i_in_data.symbol)) begin
                                gt_ra = {r_cur, sidx(i_in_data.symbol)};
                                n_state = S_PC_CHK;
                            end
                        end
                        mpmc_pkg::KIND_PEND: begin
                            if (!r_built) begin
                                if (i_in_data.pattern_id == '0) begin
                                    n_res.status = mpmc_pkg::ST_NO_ID;
                                end else if (id_ok(i_in_data.pattern_id)) begin
                                    np_we = 1'b1;
                                    np_wa = r_cur;
                                    np_wd = i_in_data.pattern_id;
                                end
                                n_cur = '0;
                            end
                        end
                        mpmc_pkg::KIND_BUILD: begin
                            if (!r_built) begin
                                n_i = '0;
                                n_head = '0;
                                n_tail = '0;
                                n_state = S_BA_RD;
                            end
                        end
                        mpmc_pkg::KIND_START: begin
                            n_scan = '0;
                            n_mi = '0;
                            n_state = S_MC_CLR;
                        end
                        mpmc_pkg::KIND_SCAN: begin
                            if (sym_ok(i_in_data.symbol)) begin
                                gt_ra = {r_scan, sidx(i_in_data.symbol)};
                                n_state = S_SC_V;
                            end else begin
                                n_scan = '0;
                            end
                        end
                        mpmc_pkg::KIND_READ: begin
                            if (i_in_data.pattern_id == '0) begin
                                n_res.status = mpmc_pkg::ST_NO_ID;
                            end else if (id_ok(i_in_data.pattern_id)) begin
                                mc_ra = i_in_data.pattern_id[MCW-1:0];
                                n_state = S_RD_MC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // clear command: wipe the root row
            S_CLR_ROW: begin
                gt_we = 1'b1;
                gt_wa = {NB'(0), r_i[SB-1:0]};
                n_i = r_i + 1'b1;
                if (r_i == SYM_LAST) n_state = S_FIN;
            end
            // pattern char: follow edge or allocate
            S_PC_CHK: begin
                if (r_gt_q != '0) begin
                    n_cur = r_gt_q;
                    n_state = S_FIN;
                end else if (r_nodes >= NODE_LIM) begin
                    n_res.status = mpmc_pkg::ST_FULL;
                    n_state = S_FIN;
                end else begin
                    n_i = '0;
                    n_state = S_PC_ROW;
                end
            end
            S_PC_ROW: begin
                gt_we = 1'b1;
                gt_wa = {r_nodes[NB-1:0], r_i[SB-1:0]};
                fl_we = 1'b1;
                fl_wa = r_nodes[NB-1:0];
                np_we = 1'b1;
                np_wa = r_nodes[NB-1:0];
                n_i = r_i + 1'b1;
                if (r_i == SYM_LAST) n_state = S_PC_LINK;
            end
            S_PC_LINK: begin
                gt_we = 1'b1;
                gt_wa = {r_cur, sidx(r_sym)};
                gt_wd = r_nodes[NB-1:0];
                n_cur = r_nodes[NB-1:0];
                n_nodes = r_nodes + 1'b1;
                n_state = S_FIN;
            end
            // build: enqueue root children
            S_BA_RD: begin
                gt_ra = {NB'(0), r_i[SB-1:0]};
                n_state = S_BA_CHK;
            end
            S_BA_CHK: begin
                if (r_gt_q != '0 && r_tail < NODE_LIM) begin
                    fl_we = 1'b1;
                    fl_wa = r_gt_q;
                    q_we = 1'b1;
                    q_wa = r_tail[NB-1:0];
                    q_wd = r_gt_q;
                    n_tail = r_tail + 1'b1;
                end
                n_i = r_i + 1'b1;
                n_state = (r_i == SYM_LAST) ? S_BQ : S_BA_RD;
            end
            // build: take next node from the queue
            S_BQ: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_state = S_FIN;
                end else begin
                    q_ra = r_head[NB-1:0];
                    n_head = r_head + 1'b1;
                    n_state = S_BU;
                end
            end
            S_BU: begin
                n_u = r_q_q;
                fl_ra = r_q_q;
                n_state = S_BF;
            end
            S_BF: begin
                n_f = r_fl_q;
                n_i = '0;
                n_state = S_BC_RV;
            end
            S_BC_RV: begin
                gt_ra = {r_u, r_i[SB-1:0]};
                n_state = S_BC_RW;
            end
            S_BC_RW: begin
                n_v = r_gt_q;
                gt_ra = {r_f, r_i[SB-1:0]};
                n_state = S_BC_ACT;
            end
            S_BC_ACT: begin
                if (r_v != '0) begin
                    fl_we = 1'b1;
                    fl_wa = r_v;
                    fl_wd = r_gt_q;
                    if (r_tail < NODE_LIM) begin
                        q_we = 1'b1;
                        q_wa = r_tail[NB-1:0];
                        q_wd = r_v;
                        n_tail = r_tail + 1'b1;
                    end
                end else begin
                    gt_we = 1'b1;
                    gt_wa = {r_u, r_i[SB-1:0]};
                    gt_wd = r_gt_q;
                end
                n_i = r_i + 1'b1;
                n_state = (r_i == SYM_LAST) ? S_BQ : S_BC_RV;
            end
            // start text: zero all counters
            S_MC_CLR: begin
                mc_we = 1'b1;
                mc_wa = r_mi[MCW-1:0];
                n_mi = r_mi + 1'b1;
                if (r_mi == MC_LAST) n_state = S_FIN;
            end
            // scan: step, then walk the failure chain
            S_SC_V: begin
                n_scan = r_gt_q;
                if (r_gt_q == '0) begin
                    n_state = S_FIN;
                end else begin
                    np_ra = r_gt_q;
                    fl_ra = r_gt_q;
                    n_state = S_SC_NP;
                end
            end
            S_SC_NP: begin
                n_f = r_fl_q;
                if (r_np_q != '0 && id_ok(r_np_q)) begin
                    n_id = r_np_q;
                    mc_ra = r_np_q[MCW-1:0];
                    n_state = S_SC_MC;
                end else if (r_fl_q == '0) begin
                    n_state = S_FIN;
                end else begin
                    np_ra = r_fl_q;
                    fl_ra = r_fl_q;
                end
            end
            S_SC_MC: begin
                mc_we = !mc_sat;
                mc_wa = r_id[MCW-1:0];
                mc_wd = mc_inc;
                if (r_f == '0) begin
                    n_state = S_FIN;
                end else begin
                    np_ra = r_f;
                    fl_ra = r_f;
                    n_state = S_SC_NP;
                end
            end
            S_RD_MC: begin
                n_res.count = cnt_ext[15:0];
                n_state = S_FIN;
            end
            // hand the response to the output register
            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_odata = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_ROW;
            r_i     <= '0;
            r_mi    <= '0;
            r_nodes <= (NB+1)'(1);
            r_cur   <= '0;
            r_scan  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_mi    <= n_mi;
            r_nodes <= n_nodes;
            r_cur   <= n_cur;
            r_scan  <= n_scan;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_built <= n_built;
            r_ov    <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_u     <= n_u;
        r_f     <= n_f;
        r_v     <= n_v;
        r_sym   <= n_sym;
        r_id    <= n_id;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (gt_we) gt_mem[gt_wa] <= gt_wd;
        r_gt_q <= gt_mem[gt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) fl_mem[fl_wa] <= fl_wd;
        r_fl_q <= fl_mem[fl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (np_we) np_mem[np_wa] <= np_wd;
        r_np_q <= np_mem[np_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mc_we) mc_mem[mc_wa] <= mc_wd;
        r_mc_q <= mc_mem[mc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        r_q_q <= q_mem[q_ra];
    end

endmodule

### tb/sv/mpmc_checker.sv
// Checker for the multi-pattern match counter: watches both channels, predicts every response word
// and compares it field by field. Depends on mpmc_pkg for the word types and codes.
`timescale 1ns / 1ps

module mpmc_checker #(
    parameter int NODE_COUNT    = 4096,
    parameter int ALPHABET      = 128,
    parameter int PATTERN_COUNT = 1024,
    parameter int COUNT_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  mpmc_pkg::t_in_word  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  mpmc_pkg::t_out_word i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

    // Automaton state
    logic [11:0]           trie_next [NODE_COUNT*ALPHABET];
    logic [11:0]           fail_of   [NODE_COUNT];
    logic [9:0]            pattern_at[NODE_COUNT];
    logic [COUNT_BITS-1:0] hits      [PATTERN_COUNT];
    logic [11:0]           bfs_order [NODE_COUNT];
    int                    node_total;
    int                    insert_at;
    int                    scan_at;
    bit                    links_built;

    mpmc_pkg::t_out_word expected_words[$];

    function automatic int slot(int node, int sym);
        return (node % NODE_COUNT) * ALPHABET + (sym % ALPHABET);
    endfunction

    function automatic void wipe_row(int node);
        for (int c = 0; c < ALPHABET; c++) trie_next[slot(node, c)] = '0;
    endfunction

    // Breadth-first failure links and goto completion
    function automatic void build_links();
        int head;
        int tail;
        int u;
        int f;
        int v;
        head = 0;
        tail = 0;
        for (int c = 0; c < ALPHABET; c++) begin
            v = int'(trie_next[slot(0, c)]);
            if (v != 0 && tail < NODE_COUNT) begin
                fail_of[v] = '0;
                bfs_order[tail++] = 12'(v);
            end
        end
        while (head < tail) begin
            u = int'(bfs_order[head++]);
            f = int'(fail_of[u]);
            for (int c = 0; c < ALPHABET; c++) begin
                v = int'(trie_next[slot(u, c)]);
                if (v != 0) begin
                    fail_of[v] = trie_next[slot(f, c)];
                    if (tail < NODE_COUNT) bfs_order[tail++] = 12'(v);
                end else begin
                    trie_next[slot(u, c)] = trie_next[slot(f, c)];
                end
            end
        end
        links_built = 1'b1;
    endfunction

    // Advance the scan and count every pattern along the failure chain
    function automatic void scan_symbol(int sym);
        int v;
        int id;
        scan_at = int'(trie_next[slot(scan_at, sym)]);
        v = scan_at;
        for (int steps = 0; v != 0 && steps < NODE_COUNT; steps++) begin
            id = int'(pattern_at[v]);
            if (id != 0 && id < PATTERN_COUNT && hits[id] != COUNT_SAT) hits[id]++;
            v = int'(fail_of[v]);
        end
    endfunction

    function automatic mpmc_pkg::t_out_word predict_word(mpmc_pkg::t_in_word w);
        mpmc_pkg::t_out_word r;
        int e;
        r = '0;
        r.status = mpmc_pkg::ST_OK;
        case (w.kind)
            mpmc_pkg::KIND_CLEAR: begin
                wipe_row(0);
                fail_of[0] = '0;
                pattern_at[0] = '0;
                node_total = 1;
                insert_at = 0;
                scan_at = 0;
                links_built = 1'b0;
            end
            mpmc_pkg::KIND_PCHAR: begin
                if (!links_built && w.symbol < ALPHABET) begin
                    e = slot(insert_at, int'(w.symbol));
                    if (trie_next[e] == 0 && node_total >= NODE_COUNT) begin
                        r.status = mpmc_pkg::ST_FULL;
                    end else begin
                        if (trie_next[e] == 0) begin
                            wipe_row(node_total);
                            fail_of[node_total] = '0;
                            pattern_at[node_total] = '0;
                            trie_next[e] = 12'(node_total);
                            node_total++;
                        end
                        insert_at = int'(trie_next[e]);
                    end
                end
            end
            mpmc_pkg::KIND_PEND: begin
                if (!links_built) begin
                    if (w.pattern_id == 0) r.status = mpmc_pkg::ST_NO_ID;
                    else if (w.pattern_id < PATTERN_COUNT) pattern_at[insert_at] = w.pattern_id;
                    insert_at = 0;
                end
            end
            mpmc_pkg::KIND_BUILD: if (!links_built) build_links();
            mpmc_pkg::KIND_START: begin
                for (int i = 0; i < PATTERN_COUNT; i++) hits[i] = '0;
                scan_at = 0;
            end
            mpmc_pkg::KIND_SCAN: begin
                if (w.symbol >= ALPHABET) scan_at = 0;
                else scan_symbol(int'(w.symbol));
            end
            mpmc_pkg::KIND_READ: begin
                if (w.pattern_id == 0) r.status = mpmc_pkg::ST_NO_ID;
                else if (w.pattern_id < PATTERN_COUNT) r.count = hits[w.pattern_id];
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        for (int i = 0; i < NODE_COUNT*ALPHABET; i++) trie_next[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            fail_of[i] = '0;
            pattern_at[i] = '0;
            bfs_order[i] = '0;
        end
        for (int i = 0; i < PATTERN_COUNT; i++) hits[i] = '0;
        node_total = 1;
        insert_at = 0;
        scan_at = 0;
        links_built = 1'b0;
        o_fail_count = 0;
    end

    assign o_pending = expected_words.size();

    // Predict on each accepted input word, compare each accepted output word
    always @(posedge i_clk) begin
        mpmc_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) expected_words.push_back(predict_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: count %0d status %0d",
                           i_out_data.count, i_out_data.status);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_data.count !== want.count) begin
                        $error("count: expected %0d actual %0d", want.count, i_out_data.count);
                        o_fail_count++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d actual %0d",
                               want.status, i_out_data.status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb.sv
// Testbench top for the multi-pattern match counter: clock, reset, stimulus and verdict.
// Depends on mpmc_pkg, multi_pattern_match_counter_unit and mpmc_checker.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 20_000_000;
    // kind code with no function
    localparam logic [2:0] KIND_SPARE = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    mpmc_pkg::t_in_word  in_data;
    logic      out_valid;
    logic      out_stall;
    mpmc_pkg::t_out_word out_data;
    int        fail_count;
    int        pending;
    int        cycles;
    int        idle_pct;
    int        stall_pct;
    int        words_sent;

    multi_pattern_match_counter_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    mpmc_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver stall, redrawn every falling edge
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one word after random idle cycles and hold it until accepted
    task automatic send_word(logic [2:0] kind, logic [6:0] sym, logic [9:0] id);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind, symbol: sym, pattern_id: id};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic set_phase(int n);
        case (n % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    // Pattern text of a random session: mostly a four-letter subset
    function automatic logic [6:0] pick_sym(int base);
        if ($urandom_range(7) == 0) return 7'($urandom);
        return 7'(base + $urandom_range(3));
    endfunction

    function automatic logic [9:0] pick_id(int pool);
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return 10'($urandom);
        return 10'(pool + $urandom_range(7));
    endfunction

    // Directed part: the classic he/she patterns plus the corner cases
    task automatic run_directed();
        string txt;
        txt = "ushers";
        send_word(mpmc_pkg::KIND_CLEAR, 7'd0, 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("h"), 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("e"), 10'd0);
        send_word(mpmc_pkg::KIND_PEND, 7'd0, 10'd1);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("s"), 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("h"), 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("e"), 10'd0);
        send_word(mpmc_pkg::KIND_PEND, 7'd0, 10'd2);
        send_word(mpmc_pkg::KIND_PCHAR, 7'h7f, 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'h00, 10'd0);
        send_word(mpmc_pkg::KIND_PEND, 7'd0, 10'd1023);
        send_word(mpmc_pkg::KIND_PEND, 7'd0, 10'd5);   // empty pattern lands on the root
        send_word(mpmc_pkg::KIND_PCHAR, 7'("h"), 10'd0);
        send_word(mpmc_pkg::KIND_PEND, 7'h7f, 10'd0);
        send_word(mpmc_pkg::KIND_START, 7'd0, 10'd0);  // scan on the partial trie
        send_word(mpmc_pkg::KIND_SCAN, 7'("s"), 10'd0);
        send_word(mpmc_pkg::KIND_SCAN, 7'("h"), 10'd0);
        send_word(mpmc_pkg::KIND_SCAN, 7'("e"), 10'd0);
        send_word(mpmc_pkg::KIND_READ, 7'd0, 10'd2);
        send_word(mpmc_pkg::KIND_BUILD, 7'd0, 10'd0);
        send_word(mpmc_pkg::KIND_BUILD, 7'd0, 10'd0);
        send_word(mpmc_pkg::KIND_PCHAR, 7'("x"), 10'd0);   // edit after build is ignored
        send_word(mpmc_pkg::KIND_START, 7'd0, 10'd0);
        foreach (txt[i]) send_word(mpmc_pkg::KIND_SCAN, 7'(txt[i]), 10'd0);
        send_word(mpmc_pkg::KIND_SCAN, 7'h7f, 10'd0);
        send_word(mpmc_pkg::KIND_SCAN, 7'h00, 10'd0);
        send_word(mpmc_pkg::KIND_READ, 7'd0, 10'd1);
        send_word(mpmc_pkg::KIND_READ, 7'd0, 10'd1023);
        send_word(mpmc_pkg::KIND_READ, 7'd0, 10'd0);
        send_word(mpmc_pkg::KIND_READ, 7'd0, 10'd5);
        send_word(KIND_SPARE, 7'h7f, 10'h3ff);
    endtask

    // One random session: patterns, build, text, reads, with some noise
    task automatic run_session();
        int base;
        int pool;
        int len;
        base = $urandom_range(124);
        pool = $urandom_range(1, 1000);
        if ($urandom_range(9) != 0)
            send_word(mpmc_pkg::KIND_CLEAR, 7'($urandom), 10'($urandom));
        repeat ($urandom_range(1, 5)) begin
            len = $urandom_range(4);
            repeat (len) send_word(mpmc_pkg::KIND_PCHAR, pick_sym(base), 10'($urandom));
            send_word(mpmc_pkg::KIND_PEND, 7'($urandom), pick_id(pool));
        end
        if ($urandom_range(9) != 0)
            send_word(mpmc_pkg::KIND_BUILD, 7'($urandom), 10'($urandom));
        if ($urandom_range(4) != 0)
            send_word(mpmc_pkg::KIND_START, 7'($urandom), 10'($urandom));
        repeat ($urandom_range(8, 30)) begin
            case ($urandom_range(19))
                0: send_word(3'($urandom_range(7)), 7'($urandom), 10'($urandom));
                1, 2: send_word(mpmc_pkg::KIND_READ, 7'($urandom), pick_id(pool));
                default: send_word(mpmc_pkg::KIND_SCAN, pick_sym(base), 10'($urandom));
            endcase
        end
        for (int i = 0; i < 8; i++)
            send_word(mpmc_pkg::KIND_READ, 7'($urandom), 10'(pool + i));
    endtask

    initial begin
        int sessions;
        cycles = 0;
        words_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        sessions = 0;
        while (words_sent < 1600) begin
            set_phase(sessions);
            run_session();
            sessions++;
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mpmc_pkg.sv
hw/rtl/mpmc_sat_inc.sv
hw/rtl/multi_pattern_match_counter_unit.sv
tb/sv/mpmc_checker.sv
tb/sv/tb.sv
